// ===== src/wdt_pkg.sv =====
package wdt_pkg;

  localparam int unsigned CNT_W      = 64;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned MS_W       = 32;
  localparam int unsigned TPS_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned TICKS_W    = 55;
  localparam int unsigned NUM_STAGES = 10;
  localparam int unsigned NUM_SLOTS_DEF = 8;

  typedef enum logic {
    OP_SET   = 1'b0,
    OP_CHECK = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TOO_LONG    = 2'd1,
    ST_BAD_READING = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNTER_BASE     = 2'd0,
    CFG_COUNTER_SPAN     = 2'd1,
    CFG_TICKS_PER_SECOND = 2'd2,
    CFG_COUNTS_DOWN      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    counter_reading;
    logic [MS_W-1:0]     timeout_ms;
  } in_item_t;

  typedef struct packed {
    status_e status;
    logic    expired;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  data;
  } tbl_wr_t;

endpackage

// ===== src/wdt_tick_conv.sv =====
module wdt_tick_conv import wdt_pkg::*; (
  input  logic               clk_i,
  input  logic [5:1]         stage_en_i,
  input  logic [TPS_W-1:0]   tps_i,
  input  logic [MS_W-1:0]    ms_i,
  output logic [TICKS_W-1:0] ticks_o
);

  // x / 1000 == (x * RECIP) >> RECIP_SHIFT for every 32-bit x.
  localparam int unsigned RECIP_W     = 29;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP = 29'd274877907;
  localparam logic [MS_W-1:0]    MS_PER_SEC = 32'd1000;
  localparam int unsigned Q_W  = 23;
  localparam int unsigned R_W  = 10;
  localparam int unsigned P_W  = MS_W + RECIP_W;
  localparam int unsigned D_W  = 2 * R_W;
  localparam int unsigned DP_W = D_W + RECIP_W;
  localparam int unsigned A_W  = 2 * Q_W;
  localparam int unsigned B_W  = Q_W + R_W;
  localparam int unsigned K_W  = A_W + 10;

  logic [P_W-1:0]  tps_prod, ms_prod;
  logic [Q_W-1:0]  q1_d, q2_d, q1_s1_q, q2_s1_q, q1_s2_q, q2_s2_q;
  logic [MS_W-1:0] ms_s1_q, r1_full, r2_full;
  logic [R_W-1:0]  r1_s2_q, r2_s2_q;
  logic [A_W-1:0]  a_d, a_q;
  logic [B_W-1:0]  b_d, c_d, b_q, c_q;
  logic [D_W-1:0]  d_d, d_q;
  logic [DP_W-1:0] d_prod;
  logic [K_W-1:0]  a1000_d, a1000_q, ticks_full;
  logic [B_W:0]    bc_d, bc_q;
  logic [R_W-1:0]  fd_d, fd_q;
  logic [TICKS_W-1:0] ticks_q;

  assign tps_prod = P_W'(tps_i) * P_W'(RECIP);
  assign ms_prod  = P_W'(ms_i) * P_W'(RECIP);
  assign q1_d     = tps_prod[RECIP_SHIFT +: Q_W];
  assign q2_d     = ms_prod[RECIP_SHIFT +: Q_W];

  assign r1_full = tps_i - (MS_W'(q1_s1_q) * MS_PER_SEC);
  assign r2_full = ms_s1_q - (MS_W'(q2_s1_q) * MS_PER_SEC);

  assign a_d = A_W'(q1_s2_q) * A_W'(q2_s2_q);
  assign b_d = B_W'(q1_s2_q) * B_W'(r2_s2_q);
  assign c_d = B_W'(q2_s2_q) * B_W'(r1_s2_q);
  assign d_d = D_W'(r1_s2_q) * D_W'(r2_s2_q);

  assign a1000_d = (K_W'(a_q) << 10) - (K_W'(a_q) << 4) - (K_W'(a_q) << 3);
  assign bc_d    = (B_W + 1)'(b_q) + (B_W + 1)'(c_q);
  assign d_prod  = DP_W'(d_q) * DP_W'(RECIP);
  assign fd_d    = d_prod[RECIP_SHIFT +: R_W];

  assign ticks_full = a1000_q + K_W'(bc_q) + K_W'(fd_q);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      q1_s1_q <= q1_d;
      q2_s1_q <= q2_d;
      ms_s1_q <= ms_i;
    end
    if (stage_en_i[2]) begin
      q1_s2_q <= q1_s1_q;
      q2_s2_q <= q2_s1_q;
      r1_s2_q <= r1_full[R_W-1:0];
      r2_s2_q <= r2_full[R_W-1:0];
    end
    if (stage_en_i[3]) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
    end
    if (stage_en_i[4]) begin
      a1000_q <= a1000_d;
      bc_q    <= bc_d;
      fd_q    <= fd_d;
    end
    if (stage_en_i[5]) begin
      ticks_q <= ticks_full[TICKS_W-1:0];
    end
  end

  assign ticks_o = ticks_q;

endmodule

// ===== src/wdt_slot_table.sv =====
module wdt_slot_table import wdt_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tbl_wr_t           wr_i,
  input  logic [SLOT_W-1:0] rd_slot_i,
  output logic [CNT_W-1:0]  rd_data_o
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned EXT_W = SLOT_W + IDX_W;

  logic [CNT_W-1:0] end_q [NUM_SLOTS];
  logic [EXT_W-1:0] wr_ext, rd_ext;
  logic [IDX_W-1:0] wr_idx, rd_idx;
  logic             wr_hit, rd_hit;

  assign wr_ext = {{IDX_W{1'b0}}, wr_i.slot};
  assign rd_ext = {{IDX_W{1'b0}}, rd_slot_i};
  assign wr_idx = wr_ext[IDX_W-1:0];
  assign rd_idx = rd_ext[IDX_W-1:0];
  assign wr_hit = wr_ext < EXT_W'(NUM_SLOTS);
  assign rd_hit = rd_ext < EXT_W'(NUM_SLOTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_SLOTS); i++) begin
        end_q[i] <= '0;
      end
    end else if (wr_i.en && wr_hit) begin
      end_q[wr_idx] <= wr_i.data;
    end
  end

  // A slot outside the table reads as an end time of zero.
  assign rd_data_o = rd_hit ? end_q[rd_idx] : '0;

endmodule

// ===== src/wraparound_deadline_table.sv =====
// Deadline table against a wrapping free-running counter. A set transaction converts
// the millisecond timeout to ticks, normalizes the counter reading and stores the end
// time in the addressed slot; a check transaction reports whether that slot's end time
// has passed. One transaction is accepted every clock cycle unless an output stall
// backs up the pipeline. The depth comes from the millisecond-to-tick conversion,
// which splits the 32 by 32 bit product into partial products over five stages,
// followed by the table stage, where reads and writes of a slot happen in transaction
// order, two stages of modular correction and compare, and the output register.
// The user must write configuration only while no transaction is in flight; the
// block itself does not enforce this.
module wraparound_deadline_table import wdt_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef struct packed {
    opcode_e           opcode;
    logic [SLOT_W-1:0] slot;
    logic              bad;
  } ctl_t;

  logic [CNT_W-1:0] base_q, span_q;
  logic [TPS_W-1:0] tps_q;
  logic             down_q;

  logic [NUM_STAGES-1:0] valid_q, rdy;

  in_item_t         in_q;
  logic [CNT_W-1:0] norm_d, norm_q;
  ctl_t             ctl_q [1:6];
  logic [CNT_W-1:0] now_q [2:6];
  logic [TICKS_W-1:0] ticks;
  logic [CNT_W:0]   sum_d, sum_q;
  logic             tl_d, tl_q;
  logic             wrap;
  logic [CNT_W-1:0] end_set, end_rd, rem_d, rem_q, remf_d, remf_q;
  status_e          status_d, status7_q, status8_q;
  opcode_e          op7_q, op8_q;
  tbl_wr_t          tbl_wr;
  out_item_t        out_d, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      span_q <= '1;
      tps_q  <= 32'd1000000;
      down_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_COUNTER_BASE:     base_q <= cfg_data_i;
        CFG_COUNTER_SPAN:     span_q <= cfg_data_i;
        CFG_TICKS_PER_SECOND: tps_q  <= cfg_data_i[TPS_W-1:0];
        CFG_COUNTS_DOWN:      down_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rdy[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_stall_o = !rdy[0];

  assign norm_d = in_q.counter_reading - base_q;

  wdt_tick_conv u_tick_conv (
    .clk_i      (clk_i),
    .stage_en_i (rdy[5:1]),
    .tps_i      (tps_q),
    .ms_i       (in_q.timeout_ms),
    .ticks_o    (ticks)
  );

  assign tl_d  = (ctl_q[5].opcode == OP_SET) && (CNT_W'(ticks) > (span_q >> 1));
  assign sum_d = {1'b0, now_q[5]} + (CNT_W + 1)'(ticks);

  assign wrap    = sum_q > {1'b0, span_q};
  assign end_set = wrap ? (sum_q[CNT_W-1:0] + ~span_q) : sum_q[CNT_W-1:0];

  always_comb begin
    if (tl_q) begin
      status_d = ST_TOO_LONG;
    end else if (ctl_q[6].bad) begin
      status_d = ST_BAD_READING;
    end else begin
      status_d = ST_OK;
    end
  end

  assign tbl_wr.en   = valid_q[6] && rdy[7] && (ctl_q[6].opcode == OP_SET) &&
                       (status_d == ST_OK);
  assign tbl_wr.slot = ctl_q[6].slot;
  assign tbl_wr.data = end_set;

  wdt_slot_table #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slot_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .rd_slot_i (ctl_q[6].slot),
    .rd_data_o (end_rd)
  );

  assign rem_d  = end_rd - now_q[6];
  assign remf_d = (rem_q > span_q) ? (rem_q - ~span_q) : rem_q;

  assign out_d.status  = status8_q;
  assign out_d.expired = (op8_q == OP_CHECK) && (status8_q == ST_OK) &&
                         (remf_q > (span_q >> 1));

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      in_q <= in_data_i;
    end
    if (rdy[1]) begin
      norm_q <= norm_d;
      ctl_q[1].opcode <= in_q.opcode;
      ctl_q[1].slot   <= in_q.slot;
      ctl_q[1].bad    <= norm_d > span_q;
    end
    for (int k = 2; k <= 6; k++) begin
      if (rdy[k]) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
    if (rdy[2]) begin
      now_q[2] <= down_q ? (span_q - norm_q) : norm_q;
    end
    for (int k = 3; k <= 6; k++) begin
      if (rdy[k]) begin
        now_q[k] <= now_q[k-1];
      end
    end
    if (rdy[6]) begin
      sum_q <= sum_d;
      tl_q  <= tl_d;
    end
    if (rdy[7]) begin
      rem_q     <= rem_d;
      status7_q <= status_d;
      op7_q     <= ctl_q[6].opcode;
    end
    if (rdy[8]) begin
      remf_q    <= remf_d;
      status8_q <= status7_q;
      op8_q     <= op7_q;
    end
    if (rdy[9]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign out_data_o  = out_q;

  a_ready_when_out_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o
  ) else $error("input stalled although the output register is empty");

  a_occupancy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(valid_q) == $past($countones(valid_q)) +
             int'($past(in_valid_i && !in_stall_o)) -
             int'($past(out_valid_o && !out_stall_i))
  ) else $error("pipeline lost or duplicated a transaction");

  a_expired_only_ok: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.expired |-> out_data_o.status == ST_OK
  ) else $error("expired reported on a failed transaction");

endmodule
